>>> design/sync_frame_parser_fletcher_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sync frame parser
// Shared property forms used by the parser's concurrent checks.
// ---------------------------------------------------------------------------
`ifndef SYNC_FRAME_PARSER_FLETCHER_DEFINES_SVH
`define SYNC_FRAME_PARSER_FLETCHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sfp_pkg.sv
// ---------------------------------------------------------------------------
// Sync frame parser package
// Parse phases, result kinds, sync codes and the result record.
// ---------------------------------------------------------------------------
package sfp_pkg;

  // Sync pair that opens every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Payload limit after reset.
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CK1     = 4'd7,
    PH_CK2     = 4'd8
  } phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CKERR   = 2'd2,
    KIND_TOOLONG = 2'd3
  } kind_t;

  // One result item.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] byte_index;
    logic [7:0]  data_byte;
    logic [15:0] payload_length;
  } result_t;

  // Stage control between the input register and the parser core.
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

>>> design/sfp_in_stage.sv
// ---------------------------------------------------------------------------
// Sync frame parser input register
// Holds one received byte until the parser core consumes it.
// ---------------------------------------------------------------------------
module sfp_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       out_free,  // output register can take a result this cycle
  output sfp_pkg::stage_ctl_t ctl,
  output logic [7:0] rx_byte
);

  logic held;
  logic advance;

  // The held byte moves on whenever the output side has room.
  assign advance  = held && out_free;
  assign s_tready = !held || advance;

  assign ctl.valid   = held;
  assign ctl.advance = advance;

  // Valid flag of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
  end

  // Byte payload; no reset needed.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      rx_byte <= s_tdata;
    end
  end

endmodule

>>> design/sfp_parse_core.sv
// ---------------------------------------------------------------------------
// Sync frame parser core
// Frame state, running Fletcher sums and the per-byte parse step.
// ---------------------------------------------------------------------------
`include "sync_frame_parser_fletcher_defines.svh"

module sfp_parse_core (
  input  logic                clk,
  input  logic                rst,
  input  sfp_pkg::stage_ctl_t ctl,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  output logic                emit,
  output sfp_pkg::result_t    res
);

  sfp_pkg::phase_t phase, phase_next;
  logic [7:0]  frame_class, frame_class_next;
  logic [7:0]  frame_id, frame_id_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] bytes_received, bytes_received_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [15:0] max_len;

  logic [7:0]  acc_a;
  logic [7:0]  acc_b;
  logic [15:0] len_full;
  logic [15:0] cnt_inc;
  sfp_pkg::kind_t kind;
  logic [15:0] res_index;
  logic [7:0]  res_data;

  // Shared arithmetic of the step.
  assign acc_a    = sum_a + rx_byte;
  assign acc_b    = sum_b + acc_a;
  assign len_full = {rx_byte, frame_length[7:0]};
  assign cnt_inc  = bytes_received + 16'd1;

  // Payload limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= sfp_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len <= cfg_wdata;
    end
  end

  // Next-state logic of the parser.
  always_comb begin
    phase_next          = phase;
    frame_class_next    = frame_class;
    frame_id_next       = frame_id;
    frame_length_next   = frame_length;
    bytes_received_next = bytes_received;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    unique case (phase)
      sfp_pkg::PH_SYNC2: begin
        phase_next          = (rx_byte == sfp_pkg::SYNC_SECOND) ? sfp_pkg::PH_CLASS
                                                                : sfp_pkg::PH_SYNC1;
        bytes_received_next = 16'd0;
        sum_a_next          = 8'd0;
        sum_b_next          = 8'd0;
      end
      sfp_pkg::PH_CLASS: begin
        sum_a_next       = acc_a;
        sum_b_next       = acc_b;
        frame_class_next = rx_byte;
        phase_next       = sfp_pkg::PH_ID;
      end
      sfp_pkg::PH_ID: begin
        sum_a_next    = acc_a;
        sum_b_next    = acc_b;
        frame_id_next = rx_byte;
        phase_next    = sfp_pkg::PH_LEN1;
      end
      sfp_pkg::PH_LEN1: begin
        sum_a_next        = acc_a;
        sum_b_next        = acc_b;
        frame_length_next = {8'd0, rx_byte};
        phase_next        = sfp_pkg::PH_LEN2;
      end
      sfp_pkg::PH_LEN2: begin
        frame_length_next   = len_full;
        bytes_received_next = 16'd0;
        if (len_full > max_len) begin
          // Too long: restart the hunt.
          phase_next = sfp_pkg::PH_SYNC1;
          sum_a_next = 8'd0;
          sum_b_next = 8'd0;
        end else begin
          sum_a_next = acc_a;
          sum_b_next = acc_b;
          phase_next = (len_full != 16'd0) ? sfp_pkg::PH_PAYLOAD : sfp_pkg::PH_CK1;
        end
      end
      sfp_pkg::PH_PAYLOAD: begin
        sum_a_next          = acc_a;
        sum_b_next          = acc_b;
        bytes_received_next = cnt_inc;
        if (cnt_inc >= frame_length) begin
          phase_next = sfp_pkg::PH_CK1;
        end
      end
      sfp_pkg::PH_CK1: begin
        if (rx_byte != sum_a) begin
          phase_next          = sfp_pkg::PH_SYNC1;
          bytes_received_next = 16'd0;
          sum_a_next          = 8'd0;
          sum_b_next          = 8'd0;
        end else begin
          phase_next = sfp_pkg::PH_CK2;
        end
      end
      sfp_pkg::PH_CK2: begin
        phase_next          = sfp_pkg::PH_SYNC1;
        bytes_received_next = 16'd0;
        sum_a_next          = 8'd0;
        sum_b_next          = 8'd0;
      end
      default: begin
        // Sync-one hunting; unused phase codes land here as well.
        phase_next = (rx_byte == sfp_pkg::SYNC_FIRST) ? sfp_pkg::PH_SYNC2
                                                      : sfp_pkg::PH_SYNC1;
      end
    endcase
  end

  // Result logic of the parser.
  always_comb begin
    emit      = 1'b0;
    kind      = sfp_pkg::KIND_DATA;
    res_index = 16'd0;
    res_data  = 8'd0;
    unique case (phase)
      sfp_pkg::PH_LEN2: begin
        if (len_full > max_len) begin
          emit = 1'b1;
          kind = sfp_pkg::KIND_TOOLONG;
        end
      end
      sfp_pkg::PH_PAYLOAD: begin
        emit      = 1'b1;
        res_index = bytes_received;
        res_data  = rx_byte;
      end
      sfp_pkg::PH_CK1: begin
        if (rx_byte != sum_a) begin
          emit = 1'b1;
          kind = sfp_pkg::KIND_CKERR;
        end
      end
      sfp_pkg::PH_CK2: begin
        emit = 1'b1;
        kind = (rx_byte == sum_b) ? sfp_pkg::KIND_GOOD : sfp_pkg::KIND_CKERR;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign res.kind           = kind;
  assign res.msg_class      = frame_class;
  assign res.msg_id         = frame_id;
  assign res.byte_index     = res_index;
  assign res.data_byte      = res_data;
  assign res.payload_length = frame_length_next;

  // Frame state registers, updated as each byte is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sfp_pkg::PH_SYNC1;
      frame_class    <= 8'd0;
      frame_id       <= 8'd0;
      frame_length   <= 16'd0;
      bytes_received <= 16'd0;
      sum_a          <= 8'd0;
      sum_b          <= 8'd0;
    end else if (ctl.advance) begin
      phase          <= phase_next;
      frame_class    <= frame_class_next;
      frame_id       <= frame_id_next;
      frame_length   <= frame_length_next;
      bytes_received <= bytes_received_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
    end
  end

  // Checks on the parse step.
  `SFP_ASSERT_SAME(a_advance_held, clk, rst, ctl.advance, ctl.valid,
    "parse step without a held byte")
  `SFP_ASSERT_SAME(a_payload_emits, clk, rst, ctl.advance && phase == sfp_pkg::PH_PAYLOAD,
    emit && kind == sfp_pkg::KIND_DATA, "payload byte gave no data result")
  `SFP_ASSERT_NEXT(a_index_steps, clk, rst, ctl.advance && phase == sfp_pkg::PH_PAYLOAD,
    bytes_received == $past(bytes_received) + 16'd1, "payload index did not step")
  `SFP_ASSERT_NEXT(a_status_rehunts, clk, rst,
    ctl.advance && emit && kind != sfp_pkg::KIND_DATA,
    phase == sfp_pkg::PH_SYNC1 && sum_a == 8'd0 && sum_b == 8'd0,
    "status result without restart of hunting")

endmodule

>>> design/sfp_out_stage.sv
// ---------------------------------------------------------------------------
// Sync frame parser output register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module sfp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,      // a byte is consumed this cycle
  input  logic             emit,      // that byte produces a result
  input  sfp_pkg::result_t res,
  output logic             out_free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output sfp_pkg::result_t held_res
);

  // Room for a new result when empty or when the current one is leaving.
  assign out_free = !m_tvalid || m_tready;

  // Valid flag of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (load && emit) begin
      held_res <= res;
    end
  end

endmodule

>>> design/sync_frame_parser_fletcher.sv
// ---------------------------------------------------------------------------
// Sync frame parser with Fletcher checksum
// Byte stream in, payload bytes and frame status out.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel takes one received byte per transaction in s_tdata.
//   The parser hunts for the sync pair B5 62, reads class, id and a
//   little-endian length, then passes each payload byte out on the master
//   channel with class, id and its index. After the checksum bytes one
//   status transaction reports a good frame or a checksum error; a wrong
//   first checksum byte reports the error at once. A declared length above
//   the limit in cfg_wdata gives a too-long status instead. Every status
//   returns the parser to sync hunting. An accepted byte is held in the input
//   register, then parsed into the output register, from which its result
//   is offered on the master channel.
//   Throughput: one byte per cycle while the receiver does not stall.
//   When the receiver stalls, the held result waits in the output register,
//   one more byte waits in the input register, and s_tready then drops.
//   Reset clears both registers, the frame state and sets the limit to 1024.
//   Write cfg_we/cfg_wdata only while no bytes are in flight.
// ---------------------------------------------------------------------------
module sync_frame_parser_fletcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] msg_class, [15:8] msg_id,
                                 // [31:16] byte_index, [39:32] data_byte,
                                 // [55:40] payload_length
  output logic [1:0]  m_tuser,   // [1:0] kind
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata  // max_payload_length
);

  sfp_pkg::stage_ctl_t ctl;
  sfp_pkg::result_t    res;
  sfp_pkg::result_t    held_res;
  logic [7:0]          rx_byte;
  logic                out_free;
  logic                emit;

  // Input register.
  sfp_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .out_free (out_free),
    .ctl      (ctl),
    .rx_byte  (rx_byte)
  );

  // Parse step and frame state.
  sfp_parse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .rx_byte   (rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .emit      (emit),
    .res       (res)
  );

  // Output register.
  sfp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (ctl.advance),
    .emit     (emit),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .held_res (held_res)
  );

  // Pack the result onto the master channel.
  assign m_tdata = {held_res.payload_length, held_res.data_byte, held_res.byte_index,
                    held_res.msg_id, held_res.msg_class};
  assign m_tuser = held_res.kind;

endmodule
